### hdl/xml_byte_tokenizer_defines.svh
// assertion macros for the xml byte tokenizer
// no dependencies
`ifndef XML_BYTE_TOKENIZER_DEFINES_SVH
`define XML_BYTE_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define XBT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define XBT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XBT_ASSERT(lbl, clk, rst_n, prop, msg)
`define XBT_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### hdl/xbt_pkg.sv
// types, codes and character classes for the xml byte tokenizer
// no dependencies
package xbt_pkg;

  localparam int EntityMaxDefault = 8;
  localparam int MaxTok = 8;

  typedef enum logic [4:0] {
    S_WS = 5'd0, S_NAME = 5'd1, S_SPNAME = 5'd2, S_VSTART = 5'd3, S_VALUE = 5'd4,
    S_TSTART = 5'd5, S_EMPTY = 5'd6, S_TEXT = 5'd7, S_PI = 5'd8, S_PIEND = 5'd9,
    S_CMT = 5'd10, S_CMT1 = 5'd11, S_CMT2 = 5'd12, S_DTD = 5'd13, S_DECL = 5'd14,
    S_DECLEND = 5'd15, S_CD = 5'd16, S_CD1 = 5'd17, S_CD2 = 5'd18, S_SKIP = 5'd19,
    S_ENT = 5'd20
  } state_t;

  typedef enum logic [2:0] {
    C_NONE = 3'd0, C_OPEN = 3'd1, C_CLOSE = 3'd2, C_ATTR = 3'd3, C_SQ = 3'd4, C_DQ = 3'd5
  } ctx_t;

  typedef enum logic [3:0] {
    K_TEXT = 4'd0, K_TEXTEND = 4'd1, K_SNAME = 4'd2, K_SNAMEEND = 4'd3, K_ANAME = 4'd4,
    K_AVAL = 4'd5, K_AEND = 4'd6, K_ENAME = 4'd7, K_END = 4'd8, K_EMPTY = 4'd9,
    K_ERR = 4'd10
  } kind_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
  } tok_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic is_any(input logic [7:0] c);
    return is_ws(c) || c >= 8'h20;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= 8'hC0 && c <= 8'hD6) || (c >= 8'hD8 && c <= 8'hF6) || c >= 8'hF8;
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return is_digit(c) || is_letter(c) || c == "." || c == "-" || c == "_" || c == ":";
  endfunction

endpackage

### hdl/xml_byte_tokenizer.sv
// xml byte tokenizer: registered single-pass parse of one byte per beat
// depends on xbt_pkg and xml_byte_tokenizer_defines.svh
// latency: tokens of a byte appear from the cycle after its beat is taken
// throughput: one byte per unstalled cycle while it yields at most one token;
//   a byte that yields n tokens holds the output register until the last pops
// reset: synchronous active low, parser returns to whitespace with no context
`include "xml_byte_tokenizer_defines.svh"
module xml_byte_tokenizer #(
  parameter int ENTITY_MAX = xbt_pkg::EntityMaxDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_kind,
  output logic [7:0] out_char_value,
  output logic       out_last_of_run
);
  import xbt_pkg::*;

  localparam int EntCap = (ENTITY_MAX < 8) ? ENTITY_MAX : 8;

  state_t      st_r, st_nxt;
  ctx_t        ctx_r, ctx_nxt;
  logic [7:0]  sp_r [7];
  logic [3:0]  spc_r, spc_nxt;
  logic [7:0]  ent_r [8];
  logic [3:0]  entc_r, entc_nxt;
  logic        sp_we, ent_we;

  tok_t        tok_r [MaxTok];
  tok_t        tok_nxt [MaxTok];
  logic [3:0]  cnt_r, cnt_nxt;
  logic [2:0]  rd_r;
  logic [3:0]  n;

  logic        take, pop, busy;
  logic [7:0]  c;

  assign c         = in_byte;
  assign busy      = cnt_r != 4'd0;
  assign pop       = busy && !out_stall;
  assign in_stall  = busy && !(cnt_r == 4'd1 && rd_r == 3'd0 && !out_stall) &&
                     !(pop && {1'b0, rd_r} + 4'd1 == cnt_r);
  assign take      = in_valid && !in_stall;

  assign out_valid       = busy;
  assign out_kind        = tok_r[rd_r].kind;
  assign out_char_value  = tok_r[rd_r].ch;
  assign out_last_of_run = {1'b0, rd_r} + 4'd1 == cnt_r;

  function automatic logic sp_is(input logic [7:0] b [7], input logic [55:0] s);
    logic r;
    r = 1'b1;
    for (int i = 0; i < 7; i++) if (b[i] != s[55 - 8 * i -: 8]) r = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [3:0] en;
    logic [3:0] spn;
    logic       val;
    kind_t      ek;
    st_nxt   = st_r;
    ctx_nxt  = ctx_r;
    spc_nxt  = spc_r;
    entc_nxt = entc_r;
    sp_we    = 1'b0;
    ent_we   = 1'b0;
    n        = 4'd0;
    en       = (entc_r > 4'd8) ? 4'd8 : entc_r;
    spn      = (spc_r < 4'd8) ? spc_r + 4'd1 : 4'd8;
    val      = ctx_r != C_NONE;
    ek       = val ? K_AVAL : K_TEXT;
    for (int i = 0; i < MaxTok; i++) tok_nxt[i] = '{kind: K_ERR, ch: 8'd0};
    if (c != 8'd0) begin
      case (st_r)
        S_WS: begin
          if (!is_ws(c)) begin
            if (ctx_r == C_NONE) begin
              if (c == "<") st_nxt = S_TSTART;
              else if (c == "&") begin
                entc_nxt = 4'd0; st_nxt = S_ENT;
              end else if (is_any(c)) begin
                tok_nxt[0] = '{K_TEXT, c}; n = 4'd1; st_nxt = S_TEXT;
              end else n = 4'd1;
            end else if (ctx_r == C_ATTR) begin
              if (c == "/") st_nxt = S_EMPTY;
              else if (c == ">") begin
                st_nxt = S_WS; ctx_nxt = C_NONE;
              end else if (is_name(c)) begin
                tok_nxt[0] = '{K_ANAME, c}; n = 4'd1; st_nxt = S_NAME;
              end else n = 4'd1;
            end else if (ctx_r == C_CLOSE) begin
              if (c == ">") begin
                tok_nxt[0] = '{K_END, 8'd0}; st_nxt = S_WS; ctx_nxt = C_NONE;
              end
              n = 4'd1;
            end else if (ctx_r <= C_DQ) n = 4'd1;
          end
        end
        S_NAME: begin
          if (ctx_r == C_OPEN) begin
            n = 4'd1;
            if (is_name(c)) tok_nxt[0] = '{K_SNAME, c};
            else if (c == ">") begin
              tok_nxt[0] = '{K_SNAMEEND, 8'd0}; st_nxt = S_WS; ctx_nxt = C_NONE;
            end else if (is_ws(c)) begin
              tok_nxt[0] = '{K_SNAMEEND, 8'd0}; st_nxt = S_WS; ctx_nxt = C_ATTR;
            end else if (c == "/") begin
              tok_nxt[0] = '{K_SNAMEEND, 8'd0}; st_nxt = S_EMPTY;
            end
          end else if (ctx_r == C_CLOSE) begin
            if (is_name(c)) begin
              tok_nxt[0] = '{K_ENAME, c}; n = 4'd1;
            end else if (c == ">") begin
              tok_nxt[0] = '{K_END, 8'd0}; n = 4'd1; st_nxt = S_WS; ctx_nxt = C_NONE;
            end else if (is_ws(c)) st_nxt = S_WS;
            else n = 4'd1;
          end else if (ctx_r == C_ATTR) begin
            if (is_name(c)) begin
              tok_nxt[0] = '{K_ANAME, c}; n = 4'd1;
            end else if (c == "=") st_nxt = S_VSTART;
            else n = 4'd1;
          end else if (ctx_r <= C_DQ) n = 4'd1;
        end
        S_SPNAME: begin
          if (is_name(c) || c == "[") begin
            sp_we   = spc_r < 4'd7;
            spc_nxt = spn;
            if (spn == 4'd2 && (spc_r == 4'd1 ? (sp_r[0] == "-" && c == "-") :
                                (sp_r[0] == "-" && sp_r[1] == "-"))) begin
              spc_nxt = 4'd0; st_nxt = S_CMT; ctx_nxt = C_NONE;
            end else if (spn == 4'd7 && spc_r == 4'd6 && c == "[" &&
                         sp_r[0] == "[" && sp_r[1] == "C" && sp_r[2] == "D" &&
                         sp_r[3] == "A" && sp_r[4] == "T" && sp_r[5] == "A") begin
              spc_nxt = 4'd0; st_nxt = S_CD; ctx_nxt = C_NONE;
            end
          end else if (is_ws(c)) begin
            spc_nxt = 4'd0; ctx_nxt = C_NONE;
            st_nxt = (spc_r == 4'd7 && sp_is(sp_r, "DOCTYPE")) ? S_DTD : S_SKIP;
          end else n = 4'd1;
        end
        S_VSTART: begin
          if (c == "\"") begin
            st_nxt = S_VALUE; ctx_nxt = C_DQ;
          end else if (c == "'") begin
            st_nxt = S_VALUE; ctx_nxt = C_SQ;
          end else n = 4'd1;
        end
        S_VALUE: begin
          if ((c == "\"" && ctx_r == C_DQ) || (c == "'" && ctx_r == C_SQ)) begin
            tok_nxt[0] = '{K_AEND, 8'd0}; n = 4'd1; st_nxt = S_WS; ctx_nxt = C_ATTR;
          end else if (c == "&") begin
            entc_nxt = 4'd0; st_nxt = S_ENT;
          end else if (is_any(c) && c != "<") begin
            tok_nxt[0] = '{K_AVAL, c}; n = 4'd1;
          end else n = 4'd1;
        end
        S_TSTART: begin
          if (c == "!") begin
            spc_nxt = 4'd0; st_nxt = S_SPNAME; ctx_nxt = C_NONE;
          end else if (c == "?") begin
            st_nxt = S_PI; ctx_nxt = C_NONE;
          end else if (c == "/") begin
            st_nxt = S_NAME; ctx_nxt = C_CLOSE;
          end else if (is_name(c)) begin
            tok_nxt[0] = '{K_SNAME, c}; n = 4'd1; st_nxt = S_NAME; ctx_nxt = C_OPEN;
          end else n = 4'd1;
        end
        S_EMPTY: begin
          n = 4'd1;
          if (c == ">") begin
            tok_nxt[0] = '{K_EMPTY, 8'd0}; st_nxt = S_WS; ctx_nxt = C_NONE;
          end
        end
        S_ENT: begin
          if (ctx_r == C_SQ || ctx_r == C_DQ || ctx_r == C_NONE) begin
            if (c == ";") begin
              entc_nxt = 4'd0;
              st_nxt   = val ? S_VALUE : S_TEXT;
              n        = 4'd1;
              if (en == 4'd2 && ent_r[0] == "l" && ent_r[1] == "t")
                tok_nxt[0] = '{ek, "<"};
              else if (en == 4'd2 && ent_r[0] == "g" && ent_r[1] == "t")
                tok_nxt[0] = '{ek, ">"};
              else if (en == 4'd3 && ent_r[0] == "a" && ent_r[1] == "m" && ent_r[2] == "p")
                tok_nxt[0] = '{ek, "&"};
              else if (en == 4'd4 && ent_r[0] == "q" && ent_r[1] == "u" &&
                       ent_r[2] == "o" && ent_r[3] == "t")
                tok_nxt[0] = '{ek, "\""};
              else if (en == 4'd4 && ent_r[0] == "a" && ent_r[1] == "p" &&
                       ent_r[2] == "o" && ent_r[3] == "s")
                tok_nxt[0] = '{ek, "'"};
              else if (en == 4'd3 && ent_r[0] == "#" && is_digit(ent_r[1]) &&
                       is_digit(ent_r[2]))
                tok_nxt[0] = '{ek, {ent_r[1][3:0], 3'b000} + {2'b00, ent_r[1][3:0], 1'b0}
                                   + {4'd0, ent_r[2][3:0]}};
              else begin
                n = en;
                for (int i = 0; i < MaxTok; i++) tok_nxt[i] = '{ek, ent_r[i]};
              end
            end else if ((is_name(c) || c == "#") && entc_r < 4'(EntCap)) begin
              ent_we = 1'b1; entc_nxt = entc_r + 4'd1;
            end else n = 4'd1;
          end else if (ctx_r <= C_DQ) n = 4'd1;
        end
        S_CMT: begin
          if (c == "-") st_nxt = S_CMT1;
          else if (!is_any(c)) n = 4'd1;
        end
        S_CMT1: begin
          if (c == "-") st_nxt = S_CMT2;
          else if (is_any(c)) st_nxt = S_CMT;
          else n = 4'd1;
        end
        S_CMT2: begin
          if (c == ">") begin
            st_nxt = S_WS; ctx_nxt = C_NONE;
          end else n = 4'd1;
        end
        S_TEXT: begin
          if (c == "<") begin
            tok_nxt[0] = '{K_TEXTEND, 8'd0}; n = 4'd1; st_nxt = S_TSTART; ctx_nxt = C_NONE;
          end else if (c == "&") begin
            entc_nxt = 4'd0; st_nxt = S_ENT;
          end else begin
            tok_nxt[0] = '{K_TEXT, c}; n = 4'd1;
          end
        end
        S_PI: if (c == "?") st_nxt = S_PIEND;
        S_PIEND: begin
          if (c == ">") begin
            st_nxt = S_WS; ctx_nxt = C_NONE;
          end else n = 4'd1;
        end
        S_DTD: begin
          if (c == "[") st_nxt = S_DECL;
          else if (c == ">") begin
            st_nxt = S_WS; ctx_nxt = C_NONE;
          end
        end
        S_DECL: if (c == "]") st_nxt = S_DECLEND;
        S_DECLEND: begin
          if (c == ">") begin
            st_nxt = S_WS; ctx_nxt = C_NONE;
          end else if (!is_ws(c)) n = 4'd1;
        end
        S_CD: begin
          if (c == "]") st_nxt = S_CD1;
          else begin
            tok_nxt[0] = '{K_TEXT, c}; n = 4'd1;
          end
        end
        S_CD1: begin
          if (c == "]") st_nxt = S_CD2;
          else begin
            tok_nxt[0] = '{K_TEXT, "]"}; tok_nxt[1] = '{K_TEXT, c}; n = 4'd2;
            st_nxt = S_CD;
          end
        end
        S_CD2: begin
          if (c == ">") begin
            tok_nxt[0] = '{K_TEXTEND, 8'd0}; n = 4'd1; st_nxt = S_TEXT; ctx_nxt = C_NONE;
          end else if (c == "]") begin
            tok_nxt[0] = '{K_TEXT, "]"}; n = 4'd1;
          end else begin
            tok_nxt[0] = '{K_TEXT, "]"}; tok_nxt[1] = '{K_TEXT, "]"};
            tok_nxt[2] = '{K_TEXT, c}; n = 4'd3; st_nxt = S_CD;
          end
        end
        S_SKIP: begin
          if (c == ">") begin
            st_nxt = S_WS; ctx_nxt = C_NONE;
          end
        end
        default: ;
      endcase
    end
    // an error leaves state untouched
    if (n == 4'd1 && tok_nxt[0].kind == K_ERR) begin
      st_nxt = st_r; ctx_nxt = ctx_r; spc_nxt = spc_r; entc_nxt = entc_r;
      sp_we = 1'b0; ent_we = 1'b0;
    end
    cnt_nxt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_WS;
      ctx_r  <= C_NONE;
      spc_r  <= 4'd0;
      entc_r <= 4'd0;
      cnt_r  <= 4'd0;
      rd_r   <= 3'd0;
    end else begin
      if (pop) begin
        if ({1'b0, rd_r} + 4'd1 == cnt_r) begin
          cnt_r <= 4'd0; rd_r <= 3'd0;
        end else rd_r <= rd_r + 3'd1;
      end
      if (take) begin
        st_r   <= st_nxt;
        ctx_r  <= ctx_nxt;
        spc_r  <= spc_nxt;
        entc_r <= entc_nxt;
        cnt_r  <= cnt_nxt;
        rd_r   <= 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_r <= tok_nxt;
      if (sp_we) sp_r[spc_r[2:0]] <= c;
      if (ent_we) ent_r[entc_r[2:0]] <= c;
    end
  end

  `XBT_ASSERT(a_rd_in_range, clk, rst_n, busy |-> {1'b0, rd_r} < cnt_r, "read index past count")
  `XBT_ASSERT(a_no_take_midrun, clk, rst_n, (busy && !out_last_of_run) |-> in_stall, "byte taken mid run")
  `XBT_ASSERT(a_hold_on_stall, clk, rst_n, (out_valid && out_stall) |=> out_valid && $stable(rd_r), "stalled token moved")
  `XBT_ASSERT(a_ctx_legal, clk, rst_n, ctx_r <= C_DQ, "context code out of range")
  `XBT_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_valid, "output valid after reset")
endmodule
